@@ src/cmsp_pkg.sv @@
// ---------------------------------------------------------------------------
// cmsp_pkg
// Shared types and character constants of the color markup stream parser.
// ---------------------------------------------------------------------------
package cmsp_pkg;

   localparam int unsigned BYTE_W = 8;

   // characters with a meaning in the markup
   localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
   localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CH_OPEN    = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_CLOSE   = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'd48;
   localparam logic [BYTE_W-1:0] DEC_BASE   = 8'd10;
   localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'd255;

   // result kinds
   localparam logic KIND_TEXT    = 1'b0;
   localparam logic KIND_SEG_END = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_RED   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_GREEN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_BLUE  = 2'd2;

   // component being parsed inside a bracket
   typedef enum logic [1:0] {
      SEL_NONE  = 2'd0,
      SEL_RED   = 2'd1,
      SEL_GREEN = 2'd2,
      SEL_BLUE  = 2'd3
   } sel_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } color_type;

   // one result transaction
   typedef struct packed {
      logic              item_kind;
      logic [BYTE_W-1:0] char_code;
      color_type         color;
      logic              string_done;
   } result_type;

   // parsed component bookkeeping after a comma or close
   typedef struct packed {
      sel_type           sel;
      logic [BYTE_W-1:0] accum;
      color_type         parsed;
   } store_type;

endpackage

@@ src/color_markup_stream_parser.sv @@
// ---------------------------------------------------------------------------
// color_markup_stream_parser
// Parses inline color markup from a byte stream into colored characters
// and segment ends.
// ---------------------------------------------------------------------------
// One byte enters per req transaction and gives zero or one rsp transaction.
// Throughput is one byte per clock while the result register can load: a
// byte waits in the input register, is decoded combinationally against the
// parse state, and its result lands in the result register, from which rsp
// is driven. Plain bytes come out as text with the segment color, "%%" gives a
// '%', "%[r,g,b]" sets a new color (decimal, wrapping at 256) after emitting
// a segment end with the old color, and byte 0 closes the string with a
// final segment end flagged by rsp_string_done. Until a bracket closes in
// the current string the default color registers are used live. Write the
// csr registers only while no transaction is in flight.
module color_markup_stream_parser (
   input  logic                             clock,
   input  logic                             reset,
   // input byte transactions
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cmsp_pkg::BYTE_W-1:0]      req_text_byte,
   // result transactions
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_item_kind,
   output logic [cmsp_pkg::BYTE_W-1:0]      rsp_char_code,
   output logic [cmsp_pkg::BYTE_W-1:0]      rsp_seg_red,
   output logic [cmsp_pkg::BYTE_W-1:0]      rsp_seg_green,
   output logic [cmsp_pkg::BYTE_W-1:0]      rsp_seg_blue,
   output logic                             rsp_string_done,
   // configuration writes
   input  logic                             csr_write_enable,
   input  logic [cmsp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cmsp_pkg::BYTE_W-1:0]      csr_write_data
);
   import cmsp_pkg::*;

   color_type         default_ff, default_in;
   logic              byte_valid;
   logic [BYTE_W-1:0] byte_value;
   logic              advance;
   logic              can_load;
   logic              has_result;
   result_type        result;
   result_type        rsp_data;

   // default color registers, index 3 is not mapped
   always_comb begin
      default_in = default_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEFAULT_RED:   default_in.red   = csr_write_data;
            CSR_DEFAULT_GREEN: default_in.green = csr_write_data;
            CSR_DEFAULT_BLUE:  default_in.blue  = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff <= '{red: BYTE_MAX, green: BYTE_MAX, blue: BYTE_MAX};
      end else begin
         default_ff <= default_in;
      end
   end

   // a byte is decoded once the result register can take what it gives
   assign advance = byte_valid && can_load;

   cmsp_input_stage u_input_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .advance       (advance),
      .byte_valid    (byte_valid),
      .byte_value    (byte_value)
   );

   cmsp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .byte_value    (byte_value),
      .default_color (default_ff),
      .has_result    (has_result),
      .result        (result)
   );

   cmsp_result_stage u_result_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (has_result),
      .load_data  (result),
      .can_load   (can_load),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_item_kind   = rsp_data.item_kind;
   assign rsp_char_code   = rsp_data.char_code;
   assign rsp_seg_red     = rsp_data.color.red;
   assign rsp_seg_green   = rsp_data.color.green;
   assign rsp_seg_blue    = rsp_data.color.blue;
   assign rsp_string_done = rsp_data.string_done;

endmodule

@@ src/cmsp_input_stage.sv @@
// ---------------------------------------------------------------------------
// cmsp_input_stage
// Input register for one markup byte, with valid/ready handshake.
// ---------------------------------------------------------------------------
module cmsp_input_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [cmsp_pkg::BYTE_W-1:0] req_text_byte,
   input  logic                       advance,
   output logic                       byte_valid,
   output logic [cmsp_pkg::BYTE_W-1:0] byte_value
);
   import cmsp_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              take;

   // register frees up when its byte moves on
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_text_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign byte_value = byte_ff;

endmodule

@@ src/cmsp_parser.sv @@
// ---------------------------------------------------------------------------
// cmsp_parser
// Per-string parse state and the one-byte decode that updates it.
// ---------------------------------------------------------------------------
module cmsp_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [cmsp_pkg::BYTE_W-1:0] byte_value,
   input  cmsp_pkg::color_type         default_color,
   output logic                        has_result,
   output cmsp_pkg::result_type        result
);
   import cmsp_pkg::*;

   logic              pend_ff, pend_in;
   logic              brk_ff, brk_in;
   sel_type           sel_ff, sel_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   color_type         parsed_ff, parsed_in;
   color_type         active_ff, active_in;
   logic              custom_ff, custom_in;

   color_type         cur_color;
   store_type         stored;
   logic              handled;
   logic              is_digit;
   logic [BYTE_W-1:0] digit;
   logic [BYTE_W-1:0] acc_times_ten;

   // move the accumulator into the selected component
   function automatic store_type store_step(sel_type sel, logic [BYTE_W-1:0] accum,
                                            color_type parsed);
      store_type s;
      s.sel    = sel;
      s.accum  = accum;
      s.parsed = parsed;
      unique case (sel)
         SEL_RED: begin
            s.parsed.red = accum;
            s.sel        = SEL_GREEN;
            s.accum      = '0;
         end
         SEL_GREEN: begin
            s.parsed.green = accum;
            s.sel          = SEL_BLUE;
            s.accum        = '0;
         end
         SEL_BLUE: begin
            s.parsed.blue = accum;
            s.sel         = SEL_NONE;
            s.accum       = '0;
         end
         default: begin
         end
      endcase
      return s;
   endfunction

   assign cur_color     = custom_ff ? active_ff : default_color;
   assign is_digit      = (byte_value >= CH_ZERO) && (byte_value < (CH_ZERO + DEC_BASE));
   assign digit         = byte_value - CH_ZERO;
   // times ten, wrapping at 8 bits
   assign acc_times_ten = BYTE_W'({acc_ff, 3'b000} + {acc_ff, 1'b0});
   assign stored        = store_step(sel_ff, acc_ff, parsed_ff);

   always_comb begin
      pend_in    = pend_ff;
      brk_in     = brk_ff;
      sel_in     = sel_ff;
      acc_in     = acc_ff;
      parsed_in  = parsed_ff;
      active_in  = active_ff;
      custom_in  = custom_ff;
      has_result = 1'b0;
      handled    = 1'b0;
      result.item_kind   = KIND_TEXT;
      result.char_code   = '0;
      result.color       = cur_color;
      result.string_done = 1'b0;

      if (pend_ff) begin
         pend_in = 1'b0;
         if (byte_value == CH_PERCENT) begin
            has_result       = 1'b1;
            result.char_code = CH_PERCENT;
            handled          = 1'b1;
         end else if (byte_value == CH_OPEN) begin
            brk_in  = 1'b1;
            sel_in  = SEL_RED;
            handled = 1'b1;
         end
      end

      if (!handled) begin
         priority if (byte_value == CH_NUL) begin
            has_result         = 1'b1;
            result.item_kind   = KIND_SEG_END;
            result.string_done = 1'b1;
            pend_in   = 1'b0;
            brk_in    = 1'b0;
            sel_in    = SEL_NONE;
            acc_in    = '0;
            parsed_in = '0;
            custom_in = 1'b0;
         end else if (byte_value == CH_PERCENT) begin
            pend_in = 1'b1;
         end else if (!brk_ff) begin
            has_result       = 1'b1;
            result.char_code = byte_value;
         end else if (is_digit) begin
            acc_in = BYTE_W'(acc_times_ten + digit);
         end else if (byte_value == CH_COMMA) begin
            sel_in    = stored.sel;
            acc_in    = stored.accum;
            parsed_in = stored.parsed;
         end else if (byte_value == CH_CLOSE) begin
            has_result       = 1'b1;
            result.item_kind = KIND_SEG_END;
            if (sel_ff == SEL_BLUE) begin
               sel_in    = stored.sel;
               acc_in    = stored.accum;
               parsed_in = stored.parsed;
               active_in = stored.parsed;
            end else begin
               active_in = parsed_ff;
            end
            custom_in = 1'b1;
            brk_in    = 1'b0;
         end else begin
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b0;
         brk_ff    <= 1'b0;
         sel_ff    <= SEL_NONE;
         acc_ff    <= '0;
         parsed_ff <= '0;
         active_ff <= '{red: BYTE_MAX, green: BYTE_MAX, blue: BYTE_MAX};
         custom_ff <= 1'b0;
      end else if (step) begin
         pend_ff   <= pend_in;
         brk_ff    <= brk_in;
         sel_ff    <= sel_in;
         acc_ff    <= acc_in;
         parsed_ff <= parsed_in;
         active_ff <= active_in;
         custom_ff <= custom_in;
      end
   end

endmodule

@@ src/cmsp_result_stage.sv @@
// ---------------------------------------------------------------------------
// cmsp_result_stage
// Result register that holds one result transaction until it is taken.
// ---------------------------------------------------------------------------
module cmsp_result_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 load_valid,
   input  cmsp_pkg::result_type load_data,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cmsp_pkg::result_type rsp_data
);
   import cmsp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // free when empty or when the held result leaves this cycle
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = load_valid;
         if (load_valid) begin
            data_in = load_data;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
